/* hw/rtl/tct_pkg.sv */
// Shared constants, codes and control structures of the text console teletype engine.
package tct_pkg;

  localparam int unsigned COLUMNS    = 80;
  localparam int unsigned ROWS       = 25;
  localparam int unsigned CELL_COUNT = COLUMNS * ROWS;

  localparam int unsigned COL_W  = $clog2(COLUMNS);
  localparam int unsigned ROW_W  = $clog2(ROWS);
  localparam int unsigned ADDR_W = $clog2(CELL_COUNT);
  localparam int unsigned CNT_W  = $clog2(CELL_COUNT + 1);

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned COLOR_W = 4;
  localparam int unsigned RADDR_W = 11;
  localparam int unsigned LOC_W   = 11;
  localparam int unsigned CELL_W  = 16;

  localparam int unsigned TAB_STEP = 8;

  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;

  typedef enum logic [1:0] {
    MODE_PUT   = 2'd0,
    MODE_CLEAR = 2'd1,
    MODE_READ  = 2'd2,
    MODE_NOP   = 2'd3
  } mode_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic exec_put;
    logic home;
    logic cnt_clr;
    logic clr_step;
    logic scr_step;
    logic rd_cell;
    logic load_result;
  } tct_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    mode_e mode;
    logic  scroll_req;
    logic  clr_last;
    logic  scr_last;
    logic  out_free;
  } tct_stat_t;

endpackage

/* hw/rtl/text_console_teletype_unit.sv */
// Top level of the text console teletype engine: stream ports, controller and datapath.
//
// This block keeps an 80 by 25 store of 16-bit cells (attribute byte over
// character byte) and a cursor, and handles one item at a time. A put, read
// or no-operation item passes from idle through an execute and a finish
// state, where its result is loaded into the output register, and the next
// item can be taken once the controller is back in idle. A clear item sweeps
// the whole store at one cell per cycle through the single write port; a put
// that runs past the bottom row scrolls the store, reading one line ahead and
// writing back behind it. After reset the same sweep fills the store with
// blank cells (0x0F20), and no item is accepted until it ends. A finished
// result waits in the output register while the next item is already taken
// in; only if that next result is ready before the previous one has been
// taken does the block hold it. Every result carries the cursor location
// row*80+column after the item, and the cell value for a read of an address
// inside the store, else zero.
module text_console_teletype_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [7:0] char_code, [11:8] bg_colour, [15:12] fg_colour,
  // [26:16] read_address, [31:27] zero
  input  logic [31:0] s_axis_tdata_i,
  // [1:0] mode
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [10:0] cursor_location, [26:11] read_data, [31:27] zero
  output logic [31:0] m_axis_tdata_o
);
  import tct_pkg::*;

  tct_cmd_t             cmd;
  tct_stat_t            stat;
  logic [LOC_W-1:0]     cursor_location;
  logic [CELL_W-1:0]    read_data;

  // The controller sequences each item; the datapath holds the cursor, the store and the result.
  tct_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  tct_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .mode_i            (mode_e'(s_axis_tuser_i)),
    .char_code_i       (s_axis_tdata_i[7:0]),
    .bg_colour_i       (s_axis_tdata_i[11:8]),
    .fg_colour_i       (s_axis_tdata_i[15:12]),
    .read_address_i    (s_axis_tdata_i[26:16]),
    .out_ready_i       (m_axis_tready_i),
    .out_valid_o       (m_axis_tvalid_o),
    .cursor_location_o (cursor_location),
    .read_data_o       (read_data)
  );

  assign m_axis_tdata_o = {5'b0, read_data, cursor_location};

  // Only one item is in work at a time, so acceptance closes the input.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input accepted again while an item is in work");

  // The cursor always lies inside the store.
  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> 32'(m_axis_tdata_o[10:0]) < 32'(CELL_COUNT))
    else $error("cursor location outside the store");

  // Only a read gives cell data in its result.
  a_data_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_result && (stat.mode != MODE_READ) |=> m_axis_tdata_o[26:11] == '0)
    else $error("cell data in a result that is not a read");

endmodule

/* hw/rtl/tct_ctrl.sv */
// Controller state machine of the text console teletype engine.
module tct_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  tct_pkg::tct_stat_t stat_i,
  output tct_pkg::tct_cmd_t  cmd_o
);
  import tct_pkg::*;

  localparam logic [2:0] S_INIT   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_EXEC   = 3'd2;
  localparam logic [2:0] S_CLEAR  = 3'd3;
  localparam logic [2:0] S_SCROLL = 3'd4;
  localparam logic [2:0] S_FINISH = 3'd5;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_INIT: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.cnt_clr = 1'b1;
        unique case (stat_i.mode)
          MODE_PUT: begin
            cmd_o.exec_put = 1'b1;
            state_d = stat_i.scroll_req ? S_SCROLL : S_FINISH;
          end
          MODE_CLEAR: begin
            cmd_o.home = 1'b1;
            state_d    = S_CLEAR;
          end
          MODE_READ: begin
            cmd_o.rd_cell = 1'b1;
            state_d       = S_FINISH;
          end
          default: begin
            state_d = S_FINISH;
          end
        endcase
      end
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_last) begin
          state_d = S_FINISH;
        end
      end
      S_SCROLL: begin
        cmd_o.scr_step = 1'b1;
        if (stat_i.scr_last) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (stat_i.out_free) begin
          cmd_o.load_result = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: begin
        state_d = S_INIT;
      end
    endcase
  end

endmodule

/* hw/rtl/tct_datapath.sv */
// Datapath of the text console teletype engine: cursor, cell store, sweep counter, result.
module tct_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  tct_pkg::tct_cmd_t                   cmd_i,
  output tct_pkg::tct_stat_t                  stat_o,
  input  tct_pkg::mode_e                      mode_i,
  input  logic [tct_pkg::CHAR_W-1:0]          char_code_i,
  input  logic [tct_pkg::COLOR_W-1:0]         bg_colour_i,
  input  logic [tct_pkg::COLOR_W-1:0]         fg_colour_i,
  input  logic [tct_pkg::RADDR_W-1:0]         read_address_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic [tct_pkg::LOC_W-1:0]           cursor_location_o,
  output logic [tct_pkg::CELL_W-1:0]          read_data_o
);
  import tct_pkg::*;

  localparam logic [ADDR_W-1:0] COLS_A   = ADDR_W'(COLUMNS);
  localparam logic [CNT_W-1:0]  KEEP_C   = CNT_W'(CELL_COUNT - COLUMNS);
  localparam logic [CNT_W-1:0]  LAST_C   = CNT_W'(CELL_COUNT - 1);
  localparam logic [CNT_W-1:0]  END_C    = CNT_W'(CELL_COUNT);
  localparam logic [COL_W:0]    TAB_C    = (COL_W + 1)'(TAB_STEP);
  localparam logic [COL_W:0]    TABM_C   = (COL_W + 1)'(TAB_STEP - 1);
  localparam logic [COL_W:0]    COLLIM_C = (COL_W + 1)'(COLUMNS);
  localparam logic [ROW_W:0]    ROWLIM_C = (ROW_W + 1)'(ROWS);
  localparam logic [ROW_W-1:0]  ROWTOP_C = ROW_W'(ROWS - 1);

  // Item registers
  mode_e               mode_q;
  logic [CHAR_W-1:0]   char_q;
  logic [COLOR_W-1:0]  back_q, fore_q;
  logic [RADDR_W-1:0]  addr_q;

  // Cursor and sweep counter
  logic [COL_W-1:0]    col_q, col_d;
  logic [ROW_W-1:0]    row_q, row_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;

  // Cell store
  logic [CELL_W-1:0]   mem [CELL_COUNT];
  logic [CELL_W-1:0]   rdata_q;
  logic                we, re;
  logic [ADDR_W-1:0]   waddr, raddr;
  logic [CELL_W-1:0]   wdata;

  // Result register
  logic                vld_q;
  logic [LOC_W-1:0]    loc_q;
  logic [CELL_W-1:0]   data_q;

  logic [COL_W:0]      col_x;
  logic [ROW_W:0]      row_x;
  logic                printable, scroll_req, rd_ok;
  logic [ADDR_W-1:0]   cur_addr;
  logic [CNT_W-1:0]    cnt_prev;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      mode_q <= mode_i;
      char_q <= char_code_i;
      back_q <= bg_colour_i;
      fore_q <= fg_colour_i;
      addr_q <= read_address_i;
    end
  end

  // Teletype cursor movement for put mode.
  always_comb begin
    col_x     = {1'b0, col_q};
    row_x     = {1'b0, row_q};
    printable = (char_q[CHAR_W-1] == 1'b0) && (char_q >= CH_SPACE);
    priority if (char_q == CH_BS) begin
      if (col_q != '0) begin
        col_x = col_x - 1'b1;
      end
    end else if (char_q == CH_TAB) begin
      col_x = (col_x + TAB_C) & ~TABM_C;
    end else if (char_q == CH_CR) begin
      col_x = '0;
    end else if (char_q == CH_LF) begin
      col_x = '0;
      row_x = row_x + 1'b1;
    end else if (printable) begin
      col_x = col_x + 1'b1;
    end
    if (col_x >= COLLIM_C) begin
      col_x = '0;
      row_x = row_x + 1'b1;
    end
    scroll_req = (row_x >= ROWLIM_C);
  end

  assign cur_addr = ADDR_W'(row_q) * COLS_A + ADDR_W'(col_q);
  assign rd_ok    = (32'(addr_q) < 32'(CELL_COUNT));
  assign cnt_prev = cnt_q - 1'b1;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cmd_i.home) begin
      col_d = '0;
      row_d = '0;
    end else if (cmd_i.exec_put) begin
      col_d = col_x[COL_W-1:0];
      row_d = scroll_req ? ROWTOP_C : row_x[ROW_W-1:0];
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.cnt_clr) begin
      cnt_d = '0;
    end else if (cmd_i.clr_step || cmd_i.scr_step) begin
      cnt_d = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      cnt_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      cnt_q <= cnt_d;
    end
  end

  // Store port selection. A scroll reads one line ahead and writes the cell
  // fetched in the previous cycle, then blank-fills the bottom line.
  always_comb begin
    we    = 1'b0;
    waddr = cnt_q[ADDR_W-1:0];
    wdata = BLANK_CELL;
    re    = 1'b0;
    raddr = cnt_q[ADDR_W-1:0] + COLS_A;
    if (cmd_i.clr_step) begin
      we = 1'b1;
    end else if (cmd_i.exec_put) begin
      we    = printable;
      waddr = cur_addr;
      wdata = {back_q, fore_q, char_q};
    end else if (cmd_i.scr_step) begin
      re    = (cnt_q < KEEP_C);
      we    = (cnt_q != '0);
      waddr = cnt_prev[ADDR_W-1:0];
      wdata = (cnt_prev < KEEP_C) ? rdata_q : BLANK_CELL;
    end else if (cmd_i.rd_cell) begin
      re    = rd_ok;
      raddr = ADDR_W'(addr_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (cmd_i.load_result) begin
      vld_q <= 1'b1;
    end else if (out_ready_i) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_result) begin
      loc_q  <= LOC_W'(cur_addr);
      data_q <= ((mode_q == MODE_READ) && rd_ok) ? rdata_q : '0;
    end
  end

  assign stat_o.mode       = mode_q;
  assign stat_o.scroll_req = scroll_req;
  assign stat_o.clr_last   = (cnt_q == LAST_C);
  assign stat_o.scr_last   = (cnt_q == END_C);
  assign stat_o.out_free   = !vld_q || out_ready_i;

  assign out_valid_o       = vld_q;
  assign cursor_location_o = loc_q;
  assign read_data_o       = data_q;

endmodule
